/* rtl/ate_pkg.sv */
// ============================================================================
// ate_pkg
// Types, codes and constants shared by the text terminal engine modules.
// ============================================================================
package ate_pkg;

    // Field widths fixed by the item formats.
    localparam int ROW_W  = 6;
    localparam int COL_W  = 7;
    localparam int CELL_W = 16;

    // Command codes.
    localparam logic [1:0] CMD_BYTE = 2'd0;
    localparam logic [1:0] CMD_TICK = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    // Stream characters.
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_B   = 8'h42;
    localparam logic [7:0] CH_UP_C   = 8'h43;
    localparam logic [7:0] CH_UP_D   = 8'h44;
    localparam logic [7:0] CH_UP_H   = 8'h48;
    localparam logic [7:0] CH_UP_J   = 8'h4A;
    localparam logic [7:0] CH_UP_K   = 8'h4B;
    localparam logic [7:0] CH_UP_L   = 8'h4C;
    localparam logic [7:0] CH_UP_M   = 8'h4D;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_H   = 8'h68;
    localparam logic [7:0] CH_LO_L   = 8'h6C;
    localparam logic [7:0] CH_LO_M   = 8'h6D;
    localparam logic [7:0] CH_LO_S   = 8'h73;
    localparam logic [7:0] CH_LO_U   = 8'h75;

    localparam logic [CELL_W-1:0] CURSOR_TILE   = 16'hFF7F;
    localparam logic [7:0]        COLOR_RESET   = 8'hFF;
    localparam logic [7:0]        BLINK_DEFAULT = 8'd10;
    localparam logic [7:0]        COUNT_MAX     = 8'hFF;
    localparam logic [7:0]        CURSOR_MODE   = 8'd25;

    // Input item as it arrives on the port.
    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  byte_value;
        logic        batch_end;
        logic [12:0] cell_index;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic [CELL_W-1:0] read_data;
        logic [ROW_W-1:0]  row_now;
        logic [COL_W-1:0]  col_now;
        logic [ROW_W-1:0]  top_row;
        logic              cursor_on;
        logic [7:0]        color_now;
        logic              escape_busy;
    } t_out_item;

    // Item class decided at the front.
    typedef enum logic [1:0] {
        K_BYTE,
        K_TICK,
        K_READ,
        K_NONE
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  byte_value;
        logic        batch_end;
        logic [12:0] cell_index;
    } t_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GLYPH,
        S_FILL,
        S_COPY_RD,
        S_COPY_WR,
        S_READ,
        S_DONE
    } t_state;

    // Select graphic rendition: color for one parameter value.
    function automatic logic [7:0] sgr_color(input logic [7:0] color, input logic [7:0] v);
        logic [7:0] c;
        begin
            c = color;
            case (v)
                8'd0, 8'd37: c = 8'hFF;
                8'd30:       c = 8'h00;
                8'd31:       c = 8'hE0;
                8'd32:       c = 8'h1C;
                8'd33:       c = 8'hFC;
                8'd34:       c = 8'h03;
                8'd35:       c = 8'hE3;
                8'd36:       c = 8'h1F;
                default:     c = color;
            endcase
            return c;
        end
    endfunction

    // Numeric value of a stored argument of up to two characters.
    function automatic logic [7:0] arg_val(input logic [1:0] len, input logic [7:0] c0,
                                           input logic [7:0] c1);
        logic signed [13:0] d0;
        logic signed [13:0] d1;
        logic signed [13:0] v;
        begin
            d0 = $signed({6'd0, c0}) - 14'sd48;
            d1 = $signed({6'd0, c1}) - 14'sd48;
            if (len == 2'd0) begin
                v = 14'sd0;
            end else if (len == 2'd1) begin
                v = d0;
            end else begin
                v = d0 * 14'sd10 + d1;
            end
            return (v < 14'sd0) ? 8'd0 : v[7:0];
        end
    endfunction

endpackage

/* rtl/ate_ram.sv */
// ============================================================================
// ate_ram
// Generic single-write, single-read memory with a registered read port.
// ============================================================================
module ate_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4800
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/ate_front.sv */
// ============================================================================
// ate_front
// Accepts input items, classifies them and queues them for the engine.
// ============================================================================
module ate_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ate_pkg::t_in_item i_in_data,
    input  logic              i_hold,
    output logic              o_item_valid,
    output ate_pkg::t_item    o_item,
    input  logic              i_item_ready
);
    import ate_pkg::*;

    localparam int DEPTH = 2;

    t_item      r_q [DEPTH];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_count, n_count;
    logic       w_push;
    logic       w_pop;
    t_item      w_new;

    // Classify the incoming item.
    always_comb begin
        w_new.byte_value = i_in_data.byte_value;
        w_new.batch_end  = i_in_data.batch_end;
        w_new.cell_index = i_in_data.cell_index;
        unique case (i_in_data.command)
            CMD_BYTE: w_new.kind = K_BYTE;
            CMD_TICK: w_new.kind = K_TICK;
            CMD_READ: w_new.kind = K_READ;
            default:  w_new.kind = K_NONE;
        endcase
    end

    assign o_in_stall   = (r_count == 2'(DEPTH)) || i_hold;
    assign w_push       = i_in_valid && !o_in_stall;
    assign o_item_valid = (r_count != 2'd0);
    assign w_pop        = o_item_valid && i_item_ready;
    assign o_item       = r_q[r_rp];

    // Queue pointers and fill level.
    always_comb begin
        n_wp    = w_push ? ~r_wp : r_wp;
        n_rp    = w_pop ? ~r_rp : r_rp;
        n_count = r_count + 2'(w_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_new;
        end
    end

endmodule

/* rtl/ate_back.sv */
// ============================================================================
// ate_back
// Engine: parses the byte stream, walks the cell store and builds results.
// ============================================================================
module ate_back #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 60,
    parameter int TAB_STOP = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_item_valid,
    input  ate_pkg::t_item     i_item,
    output logic               o_item_ready,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_data,
    output logic               o_clearing,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ate_pkg::t_out_item o_out_data
);
    import ate_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int TW    = $clog2(TAB_STOP + 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);

    t_state            r_state, n_state;
    t_state            r_fill_ret, n_fill_ret;
    logic              r_clearing, n_clearing;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_sv_row, n_sv_row;
    logic [COL_W-1:0]  r_sv_col, n_sv_col;
    logic              r_sv_wrap, n_sv_wrap;
    logic              r_wrap, n_wrap;
    logic [ROW_W-1:0]  r_base, n_base;
    logic [7:0]        r_color, n_color;
    logic              r_cur_en, n_cur_en;
    logic              r_phase, n_phase;
    logic [7:0]        r_bcount, n_bcount;
    logic [7:0]        r_interval;
    logic              r_esc, n_esc;
    logic              r_bracket, n_bracket;
    logic              r_slot, n_slot;
    logic [1:0]        r_dpos, n_dpos;
    logic [7:0]        r_args [4];
    logic [7:0]        n_args [4];
    logic [1:0]        r_alen [2];
    logic [1:0]        n_alen [2];
    logic [7:0]        r_glyph, n_glyph;
    logic [TW-1:0]     r_reps, n_reps;
    logic [ROW_W-1:0]  r_fr, n_fr;
    logic [COL_W-1:0]  r_fc, n_fc;
    logic [ROW_W-1:0]  r_er, n_er;
    logic [COL_W-1:0]  r_ec, n_ec;
    logic [ROW_W-1:0]  r_cp_dst, n_cp_dst;
    logic [ROW_W-1:0]  r_cp_last, n_cp_last;
    logic [COL_W-1:0]  r_cp_col, n_cp_col;
    logic              r_cp_down, n_cp_down;
    logic [ROW_W:0]    r_cp_n, n_cp_n;
    logic [12:0]       r_ci, n_ci;
    logic [CELL_W-1:0] r_rd_data, n_rd_data;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    logic [TW-1:0]     w_tab_len [128];
    logic [ROW_W-1:0]  w_vrow;
    logic [COL_W-1:0]  w_vcol;
    logic [ROW_W:0]    w_psum;
    logic [ROW_W:0]    w_prow;
    logic [AW-1:0]     w_addr;
    logic [ROW_W-1:0]  w_src;
    logic              w_we;
    logic [CELL_W-1:0] w_wdata;
    logic [AW-1:0]     w_raddr;
    logic [CELL_W-1:0] w_rdata;
    logic              w_out_free;

    // Glyph count of a tab from each column.
    for (genvar i = 0; i < 128; i++) begin : g_tab
        assign w_tab_len[i] = TW'(TAB_STOP - (i % TAB_STOP));
    end

    // Source row of a line copy.
    assign w_src = r_cp_down ? ROW_W'({1'b0, r_cp_dst} - r_cp_n)
                             : ROW_W'({1'b0, r_cp_dst} + r_cp_n);

    // Visible position to be addressed in this state.
    always_comb begin
        case (r_state)
            S_FILL: begin
                w_vrow = r_fr;
                w_vcol = r_fc;
            end
            S_COPY_RD: begin
                w_vrow = w_src;
                w_vcol = r_cp_col;
            end
            S_COPY_WR: begin
                w_vrow = r_cp_dst;
                w_vcol = r_cp_col;
            end
            default: begin
                w_vrow = r_row;
                w_vcol = r_col;
            end
        endcase
    end

    // Ring mapping of the visible row to a physical cell address.
    assign w_psum = {1'b0, r_base} + {1'b0, w_vrow};
    assign w_prow = (w_psum >= (ROW_W+1)'(ROWS)) ? w_psum - (ROW_W+1)'(ROWS) : w_psum;
    assign w_addr = AW'(w_prow) * AW'(COLUMNS) + AW'(w_vcol);

    assign w_we    = (r_state == S_FILL) || (r_state == S_COPY_WR)
                     || ((r_state == S_GLYPH) && !r_wrap);
    assign w_wdata = (r_state == S_GLYPH) ? {r_color, r_glyph}
                     : (r_state == S_COPY_WR) ? w_rdata : '0;
    assign w_raddr = (r_state == S_COPY_RD) ? w_addr : AW'(i_item.cell_index);

    ate_ram #(
        .WIDTH(CELL_W),
        .DEPTH(CELLS)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_addr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign o_item_ready = (r_state == S_IDLE);
    assign o_clearing   = r_clearing;
    assign w_out_free   = !r_out_valid || !i_out_stall;
    assign o_out_valid  = r_out_valid;
    assign o_out_data   = r_out;

    // Next state and engine actions.
    always_comb begin
        logic [7:0]       b;
        logic [1:0]       argc;
        logic [7:0]       v0;
        logic [7:0]       v1;
        logic [7:0]       n;
        logic [7:0]       mode;
        logic [7:0]       room;
        logic [7:0]       nn;
        logic [7:0]       tsum;
        logic [7:0]       hr;
        logic [7:0]       hc;
        logic             done;
        logic             parse_clr;

        n_state     = r_state;
        n_fill_ret  = r_fill_ret;
        n_clearing  = r_clearing;
        n_row       = r_row;
        n_col       = r_col;
        n_sv_row    = r_sv_row;
        n_sv_col    = r_sv_col;
        n_sv_wrap   = r_sv_wrap;
        n_wrap      = r_wrap;
        n_base      = r_base;
        n_color     = r_color;
        n_cur_en    = r_cur_en;
        n_phase     = r_phase;
        n_bcount    = r_bcount;
        n_esc       = r_esc;
        n_bracket   = r_bracket;
        n_slot      = r_slot;
        n_dpos      = r_dpos;
        n_args      = r_args;
        n_alen      = r_alen;
        n_glyph     = r_glyph;
        n_reps      = r_reps;
        n_fr        = r_fr;
        n_fc        = r_fc;
        n_er        = r_er;
        n_ec        = r_ec;
        n_cp_dst    = r_cp_dst;
        n_cp_last   = r_cp_last;
        n_cp_col    = r_cp_col;
        n_cp_down   = r_cp_down;
        n_cp_n      = r_cp_n;
        n_ci        = r_ci;
        n_rd_data   = r_rd_data;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;

        b         = i_item.byte_value;
        argc      = (r_alen[r_slot] != 2'd0) ? 2'({1'b0, r_slot}) + 2'd1 : 2'({1'b0, r_slot});
        v0        = arg_val(r_alen[0], r_args[0], r_args[1]);
        v1        = arg_val(r_alen[1], r_args[2], r_args[3]);
        n         = (argc != 2'd0) ? v0 : 8'd1;
        mode      = (argc == 2'd0) ? 8'd0 : v0;
        room      = 8'(ROWS) - 8'(r_row);
        nn        = (n > room) ? room : n;
        tsum      = 8'(r_row) + nn;
        hr        = (argc >= 2'd1) ? v0 : 8'd0;
        hc        = (argc >= 2'd2) ? v1 : 8'd0;
        hr        = (hr != 8'd0) ? hr - 8'd1 : 8'd0;
        hc        = (hc != 8'd0) ? hc - 8'd1 : 8'd0;
        done      = 1'b1;
        parse_clr = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    n_state   = S_DONE;
                    n_rd_data = '0;
                    n_ci      = i_item.cell_index;
                    unique case (i_item.kind)
                        K_BYTE: begin
                            if (b == CH_ESC) begin
                                parse_clr = 1'b1;
                            end else if (r_esc) begin
                                if (!r_bracket) begin
                                    if (b == CH_LBRACK) begin
                                        n_bracket = 1'b1;
                                    end else begin
                                        parse_clr = 1'b1;
                                    end
                                end else begin
                                    if ((b >= CH_ZERO) && (b <= CH_NINE)) begin
                                        if (r_dpos < 2'd2) begin
                                            n_args[{r_slot, r_dpos[0]}] = b;
                                            n_dpos = r_dpos + 2'd1;
                                            n_alen[r_slot] = r_dpos + 2'd1;
                                            done = 1'b0;
                                        end
                                    end else if ((b == CH_SEMI) || (b == CH_QUEST)) begin
                                        if (b == CH_QUEST) begin
                                            n_alen[r_slot] = 2'd1;
                                            n_args[{r_slot, 1'b0}] = b;
                                        end
                                        n_dpos = 2'd0;
                                        if (!r_slot) begin
                                            n_slot = 1'b1;
                                            done = 1'b0;
                                        end
                                    end else begin
                                        unique case (b) inside
                                            CH_UP_A: begin
                                                n_wrap = 1'b0;
                                                n_row = (n < 8'(r_row)) ? r_row - ROW_W'(n)
                                                                        : '0;
                                            end
                                            CH_UP_B: begin
                                                n_wrap = 1'b0;
                                                n_row = (n < 8'(LAST_ROW - r_row))
                                                        ? r_row + ROW_W'(n) : LAST_ROW;
                                            end
                                            CH_UP_C: begin
                                                n_wrap = 1'b0;
                                                n_col = (n < 8'(LAST_COL - r_col))
                                                        ? r_col + COL_W'(n) : LAST_COL;
                                            end
                                            CH_UP_D: begin
                                                n_wrap = 1'b0;
                                                n_col = (n < 8'(r_col)) ? r_col - COL_W'(n)
                                                                        : '0;
                                            end
                                            CH_UP_H, CH_LO_F: begin
                                                n_wrap = 1'b0;
                                                n_row = (hr > 8'(LAST_ROW)) ? LAST_ROW
                                                                            : ROW_W'(hr);
                                                n_col = (hc > 8'(LAST_COL)) ? LAST_COL
                                                                            : COL_W'(hc);
                                            end
                                            CH_LO_S: begin
                                                n_sv_row  = r_row;
                                                n_sv_col  = r_col;
                                                n_sv_wrap = r_wrap;
                                            end
                                            CH_LO_U: begin
                                                n_row  = r_sv_row;
                                                n_col  = r_sv_col;
                                                n_wrap = r_sv_wrap;
                                            end
                                            CH_UP_J, CH_UP_K: begin
                                                n_fill_ret = S_DONE;
                                                if (mode == 8'd0) begin
                                                    n_state = S_FILL;
                                                    n_fr = r_row;
                                                    n_fc = r_col;
                                                    n_er = (b == CH_UP_J) ? LAST_ROW : r_row;
                                                    n_ec = LAST_COL;
                                                end else if (mode == 8'd1) begin
                                                    n_state = S_FILL;
                                                    n_fr = (b == CH_UP_J) ? '0 : r_row;
                                                    n_fc = '0;
                                                    n_er = r_row;
                                                    n_ec = r_col;
                                                end else if (mode == 8'd2) begin
                                                    n_state = S_FILL;
                                                    n_fr = (b == CH_UP_J) ? '0 : r_row;
                                                    n_fc = '0;
                                                    n_er = (b == CH_UP_J) ? LAST_ROW : r_row;
                                                    n_ec = LAST_COL;
                                                end
                                            end
                                            CH_UP_L: begin
                                                n_fill_ret = S_DONE;
                                                n_cp_n     = (ROW_W+1)'(nn);
                                                n_cp_down  = 1'b1;
                                                n_cp_col   = '0;
                                                n_cp_dst   = LAST_ROW;
                                                n_cp_last  = ROW_W'(tsum);
                                                n_fr = r_row;
                                                n_fc = '0;
                                                n_er = ROW_W'(tsum - 8'd1);
                                                n_ec = LAST_COL;
                                                if (nn != 8'd0) begin
                                                    n_state = (tsum <= 8'(LAST_ROW))
                                                              ? S_COPY_RD : S_FILL;
                                                end
                                            end
                                            CH_UP_M: begin
                                                n_fill_ret = S_DONE;
                                                n_cp_n     = (ROW_W+1)'(nn);
                                                n_cp_down  = 1'b0;
                                                n_cp_col   = '0;
                                                n_cp_dst   = r_row;
                                                n_cp_last  = ROW_W'(8'(LAST_ROW) - nn);
                                                n_fr = ROW_W'(8'(ROWS) - nn);
                                                n_fc = '0;
                                                n_er = LAST_ROW;
                                                n_ec = LAST_COL;
                                                if (nn != 8'd0) begin
                                                    n_state = (tsum < 8'(ROWS))
                                                              ? S_COPY_RD : S_FILL;
                                                end
                                            end
                                            CH_LO_H, CH_LO_L: begin
                                                if ((argc >= 2'd2) && (r_args[0] == CH_QUEST)
                                                    && (v1 == CURSOR_MODE)) begin
                                                    n_cur_en = (b == CH_LO_H);
                                                end
                                            end
                                            CH_LO_M: begin
                                                if (argc == 2'd0) begin
                                                    n_color = COLOR_RESET;
                                                end else if (argc == 2'd1) begin
                                                    n_color = sgr_color(r_color, v0);
                                                end else begin
                                                    n_color = sgr_color(sgr_color(r_color, v0),
                                                                        v1);
                                                end
                                            end
                                            default: begin
                                                n_color = r_color;
                                            end
                                        endcase
                                    end
                                    parse_clr = done;
                                end
                            end else begin
                                // Plain character.
                                unique case (b) inside
                                    CH_LF: begin
                                        n_wrap = 1'b0;
                                        n_col  = '0;
                                        if (r_row >= LAST_ROW) begin
                                            n_base = (r_base == LAST_ROW) ? '0
                                                                          : r_base + 1'b1;
                                            n_row  = LAST_ROW;
                                            n_fr = LAST_ROW;
                                            n_fc = '0;
                                            n_er = LAST_ROW;
                                            n_ec = LAST_COL;
                                            n_fill_ret = S_DONE;
                                            n_state = S_FILL;
                                        end else begin
                                            n_row = r_row + 1'b1;
                                        end
                                    end
                                    CH_CR: begin
                                        n_wrap = 1'b0;
                                        n_col  = '0;
                                    end
                                    CH_BS: begin
                                        n_wrap = 1'b0;
                                        if (r_col != '0) begin
                                            n_col = r_col - 1'b1;
                                        end
                                    end
                                    CH_TAB: begin
                                        n_glyph = CH_SPACE;
                                        n_reps  = w_tab_len[r_col];
                                        n_state = S_GLYPH;
                                    end
                                    default: begin
                                        n_glyph = b;
                                        n_reps  = TW'(1);
                                        n_state = S_GLYPH;
                                    end
                                endcase
                            end
                            if (parse_clr) begin
                                n_esc     = 1'b0;
                                n_bracket = 1'b0;
                                n_slot    = 1'b0;
                                n_dpos    = 2'd0;
                                n_alen[0] = 2'd0;
                                n_alen[1] = 2'd0;
                            end
                            if (b == CH_ESC) begin
                                n_esc = 1'b1;
                            end
                            if (i_item.batch_end && n_cur_en) begin
                                n_phase  = 1'b1;
                                n_bcount = 8'd0;
                            end
                        end
                        K_TICK: begin
                            n_bcount = (r_bcount < COUNT_MAX) ? r_bcount + 8'd1 : r_bcount;
                            if (r_cur_en && (n_bcount >= r_interval)) begin
                                n_bcount = 8'd0;
                                n_phase  = !r_phase;
                            end
                        end
                        K_READ: begin
                            n_state = S_READ;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            // One glyph a cycle, with a pending wrap and any scroll fill it starts taken first.
            S_GLYPH: begin
                if (r_wrap) begin
                    n_wrap = 1'b0;
                    n_col  = '0;
                    if (r_row >= LAST_ROW) begin
                        n_base = (r_base == LAST_ROW) ? '0 : r_base + 1'b1;
                        n_row  = LAST_ROW;
                        n_fr = LAST_ROW;
                        n_fc = '0;
                        n_er = LAST_ROW;
                        n_ec = LAST_COL;
                        n_fill_ret = S_GLYPH;
                        n_state = S_FILL;
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end else begin
                    if (r_col >= LAST_COL) begin
                        if (r_row >= LAST_ROW) begin
                            n_wrap = 1'b1;
                        end else begin
                            n_col = '0;
                            n_row = r_row + 1'b1;
                        end
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                    n_reps = r_reps - 1'b1;
                    if (r_reps == TW'(1)) begin
                        n_state = S_DONE;
                    end
                end
            end

            // Zero a span of cells in reading order.
            S_FILL: begin
                if ((r_fr == r_er) && (r_fc == r_ec)) begin
                    n_state = r_fill_ret;
                    if (r_fill_ret == S_IDLE) begin
                        n_clearing = 1'b0;
                    end
                end else if (r_fc == LAST_COL) begin
                    n_fc = '0;
                    n_fr = r_fr + 1'b1;
                end else begin
                    n_fc = r_fc + 1'b1;
                end
            end

            S_COPY_RD: begin
                n_state = S_COPY_WR;
            end

            // Line copy, one cell per read and write pair.
            S_COPY_WR: begin
                n_state = S_COPY_RD;
                if (r_cp_col == LAST_COL) begin
                    n_cp_col = '0;
                    if (r_cp_dst == r_cp_last) begin
                        n_state = S_FILL;
                    end else begin
                        n_cp_dst = r_cp_down ? r_cp_dst - 1'b1 : r_cp_dst + 1'b1;
                    end
                end else begin
                    n_cp_col = r_cp_col + 1'b1;
                end
            end

            // Read data is back; overlay the cursor tile, or give zero for an index past the store.
            S_READ: begin
                n_state = S_DONE;
                if ({1'b0, r_ci} < 14'(CELLS)) begin
                    if (r_cur_en && r_phase && (AW'(r_ci) == w_addr)) begin
                        n_rd_data = CURSOR_TILE;
                    end else begin
                        n_rd_data = w_rdata;
                    end
                end else begin
                    n_rd_data = '0;
                end
            end

            S_DONE: begin
                if (w_out_free) begin
                    n_state             = S_IDLE;
                    n_out_valid         = 1'b1;
                    n_out.read_data     = r_rd_data;
                    n_out.row_now       = r_row;
                    n_out.col_now       = r_col;
                    n_out.top_row       = r_base;
                    n_out.cursor_on     = r_cur_en && r_phase;
                    n_out.color_now     = r_color;
                    n_out.escape_busy   = r_esc;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_fill_ret  <= S_IDLE;
            r_clearing  <= 1'b1;
            r_fr        <= '0;
            r_fc        <= '0;
            r_er        <= LAST_ROW;
            r_ec        <= LAST_COL;
            r_row       <= '0;
            r_col       <= '0;
            r_sv_row    <= '0;
            r_sv_col    <= '0;
            r_sv_wrap   <= 1'b0;
            r_wrap      <= 1'b0;
            r_base      <= '0;
            r_color     <= COLOR_RESET;
            r_cur_en    <= 1'b1;
            r_phase     <= 1'b1;
            r_bcount    <= 8'd0;
            r_interval  <= BLINK_DEFAULT;
            r_esc       <= 1'b0;
            r_bracket   <= 1'b0;
            r_slot      <= 1'b0;
            r_dpos      <= 2'd0;
            r_alen[0]   <= 2'd0;
            r_alen[1]   <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill_ret  <= n_fill_ret;
            r_clearing  <= n_clearing;
            r_fr        <= n_fr;
            r_fc        <= n_fc;
            r_er        <= n_er;
            r_ec        <= n_ec;
            r_row       <= n_row;
            r_col       <= n_col;
            r_sv_row    <= n_sv_row;
            r_sv_col    <= n_sv_col;
            r_sv_wrap   <= n_sv_wrap;
            r_wrap      <= n_wrap;
            r_base      <= n_base;
            r_color     <= n_color;
            r_cur_en    <= n_cur_en;
            r_phase     <= n_phase;
            r_bcount    <= n_bcount;
            if (i_cfg_we) begin
                r_interval <= i_cfg_data;
            end
            r_esc       <= n_esc;
            r_bracket   <= n_bracket;
            r_slot      <= n_slot;
            r_dpos      <= n_dpos;
            r_alen      <= n_alen;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_args    <= n_args;
        r_glyph   <= n_glyph;
        r_reps    <= n_reps;
        r_cp_dst  <= n_cp_dst;
        r_cp_last <= n_cp_last;
        r_cp_col  <= n_cp_col;
        r_cp_down <= n_cp_down;
        r_cp_n    <= n_cp_n;
        r_ci      <= n_ci;
        r_rd_data <= n_rd_data;
        r_out     <= n_out;
    end

endmodule

/* rtl/ansi_text_terminal_engine_unit.sv */
// ============================================================================
// ansi_text_terminal_engine_unit
// Text terminal engine with a ring-scrolled cell store and escape parser.
// ============================================================================
// Input channel: i_in_valid / o_in_stall carry one item per transfer: a
// stream byte, a blink tick or a read of one physical cell. Output channel:
// o_out_valid / i_out_stall carry one result per item, in order, holding the
// cell word (reads only), cursor position, scroll top, color and status.
// A two-entry queue takes items while the engine works on an earlier one,
// and a result register lets the engine finish while the receiver stalls.
// Scrolling clears the new bottom row; erase clears each cell in its span;
// insert and delete line copy each moved cell by a read and a write
// (shared store port), then clear the rows left behind.
// After reset the store is zeroed; o_in_stall stays high during that
// pass. Configuration writes of the blink interval are taken at any time.
module ansi_text_terminal_engine_unit #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 60,
    parameter int TAB_STOP = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ate_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ate_pkg::t_out_item o_out_data,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_data
);
    import ate_pkg::*;

    logic  w_item_valid;
    logic  w_item_ready;
    t_item w_item;
    logic  w_clearing;

    // Front: accept, classify and queue.
    ate_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_hold      (w_clearing),
        .o_item_valid(w_item_valid),
        .o_item      (w_item),
        .i_item_ready(w_item_ready)
    );

    // Back: execute against the cell store.
    ate_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .TAB_STOP(TAB_STOP)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item_valid(w_item_valid),
        .i_item      (w_item),
        .o_item_ready(w_item_ready),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_clearing  (w_clearing),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
